// ===== rtl/vwib_pkg.sv =====
// Package for the vertex weld index builder: sizes, payload and token types,
// and the per-component tolerance compare. No dependencies.
`default_nettype none

package vwib_pkg;

    // Table size and derived widths
    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH) : 1;
    localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);

    // Component layout
    localparam int NUM_COMP    = 8;
    localparam int COMP_W      = 32;
    localparam int TOL_W       = 16;
    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(66);

    // Component slots inside a vertex
    localparam int C_POS_X  = 0;
    localparam int C_POS_Y  = 1;
    localparam int C_POS_Z  = 2;
    localparam int C_NORM_X = 3;
    localparam int C_NORM_Y = 4;
    localparam int C_NORM_Z = 5;
    localparam int C_TEX_U  = 6;
    localparam int C_TEX_V  = 7;

    // Output field widths
    localparam int OUT_IDX_W   = 8;
    localparam int OUT_COUNT_W = 9;

    typedef logic [NUM_COMP-1:0][COMP_W-1:0] vertex_t;

    // Search token passed from cell to cell
    typedef struct packed {
        logic             active;
        logic             found;
        logic             is_new;
        logic [IDX_W-1:0] idx;
    } token_t;

    // One delivered result
    typedef struct packed {
        logic [OUT_IDX_W-1:0]   vertex_index;
        logic                   is_new;
        logic                   table_full;
        logic [OUT_COUNT_W-1:0] unique_count;
    } result_t;

    // |a - b| < tol, difference formed exactly in COMP_W+1 bits
    function automatic logic comp_close(input logic [COMP_W-1:0] a,
                                        input logic [COMP_W-1:0] b,
                                        input logic [TOL_W-1:0]  tol);
        logic [COMP_W:0] diff;
        logic [COMP_W:0] mag;
        diff = {a[COMP_W-1], a} - {b[COMP_W-1], b};
        mag  = diff[COMP_W] ? (~diff + 1'b1) : diff;
        return mag < (COMP_W+1)'(tol);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/vwib_cell.sv =====
// One table cell of the vertex weld index builder: holds one unique vertex
// and its valid bit, and passes the search token on. Uses vwib_pkg.
`default_nettype none

module vwib_cell
    import vwib_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             clear,
    input  wire vertex_t          query,
    input  wire logic [TOL_W-1:0] tolerance,
    input  wire token_t           tok_in,
    output token_t                tok_out
);

    token_t  tok_reg;
    logic    valid_reg;
    logic    valid_next;
    vertex_t entry_reg;
    logic    match;
    logic    searching;
    logic    hit;
    logic    append;

    // All eight components within tolerance
    always_comb
    begin
        match = 1'b1;
        for (int c = 0; c < NUM_COMP; c++)
        begin
            if (!comp_close(entry_reg[c], query[c], tolerance))
                match = 1'b0;
        end
    end

    assign searching = tok_reg.active && !tok_reg.found;
    assign hit       = searching && valid_reg && match;
    // first empty cell: valid cells form a prefix, so the search missed
    assign append    = searching && !valid_reg;

    // Token update
    always_comb
    begin
        tok_out = tok_reg;
        if (hit)
        begin
            tok_out.found = 1'b1;
        end
        else if (append)
        begin
            tok_out.found  = 1'b1;
            tok_out.is_new = 1'b1;
        end
        else if (searching)
        begin
            tok_out.idx = tok_reg.idx + 1'b1;
        end
    end

    always_comb
    begin
        priority if (clear)
            valid_next = 1'b0;
        else if (append)
            valid_next = 1'b1;
        else
            valid_next = valid_reg;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            tok_reg   <= tok_in;
            valid_reg <= valid_next;
        end
    end

    // Stored vertex
    always_ff @(posedge clk)
    begin
        if (append)
            entry_reg <= query;
    end

endmodule

`default_nettype wire

// ===== rtl/vertex_weld_index_builder.sv =====
// Top level of the vertex weld index builder: request handshakes, tolerance
// register, result buffering and the chain of vwib_cell. Uses vwib_pkg.
//
//   channel   direction  signals
//   input     in         in_valid, in_ready, first_of_model, pos_*, norm_*, tex_*
//   output    out        out_valid, out_ready, vertex_index, is_new,
//                        table_full, unique_count
//   config    in         cfg_wr_en, cfg_wr_data
//
// A request reaches the output register once the search token has walked the
// cell chain, one cell per cycle. One request is in the chain at a time;
// in_ready returns the cycle after the result is loaded.
// Reset empties the table at once (valid bits clear); no clearing pass.
// A stalled output parks the next result in a holding slot; input stays closed.
`default_nettype none

module vertex_weld_index_builder
    import vwib_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_wr_en,
    input  wire logic [TOL_W-1:0]         cfg_wr_data,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic                     first_of_model,
    input  wire logic signed [COMP_W-1:0] pos_x,
    input  wire logic signed [COMP_W-1:0] pos_y,
    input  wire logic signed [COMP_W-1:0] pos_z,
    input  wire logic signed [COMP_W-1:0] norm_x,
    input  wire logic signed [COMP_W-1:0] norm_y,
    input  wire logic signed [COMP_W-1:0] norm_z,
    input  wire logic signed [COMP_W-1:0] tex_u,
    input  wire logic signed [COMP_W-1:0] tex_v,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic [OUT_IDX_W-1:0]          vertex_index,
    output logic                          is_new,
    output logic                          table_full,
    output logic [OUT_COUNT_W-1:0]        unique_count
);

    logic              accept;
    logic [TOL_W-1:0]  tol_reg;
    vertex_t           query_reg;
    logic              busy_reg;
    logic              busy_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    token_t            head_tok;
    token_t            link [TABLE_DEPTH+1];
    token_t            chain_out;
    result_t           chain_res;
    result_t           pend_res_reg;
    logic              pend_reg;
    logic              pend_next;
    result_t           out_res_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              slot_free;
    logic              load_out;
    logic [IDX_W+OUT_IDX_W-1:0]     idx_wide;
    logic [COUNT_W+OUT_COUNT_W-1:0] count_wide;

    assign in_ready = !busy_reg;
    assign accept   = in_valid && in_ready;

    // Tolerance register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tol_reg <= TOL_RESET;
        else if (cfg_wr_en)
            tol_reg <= cfg_wr_data;
    end

    // Query capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            query_reg[C_POS_X]  <= pos_x;
            query_reg[C_POS_Y]  <= pos_y;
            query_reg[C_POS_Z]  <= pos_z;
            query_reg[C_NORM_X] <= norm_x;
            query_reg[C_NORM_Y] <= norm_y;
            query_reg[C_NORM_Z] <= norm_z;
            query_reg[C_TEX_U]  <= tex_u;
            query_reg[C_TEX_V]  <= tex_v;
        end
    end

    // Token injection at the head of the chain
    always_comb
    begin
        head_tok        = '0;
        head_tok.active = accept;
    end

    assign link[0] = head_tok;

    // Cell chain
    for (genvar k = 0; k < TABLE_DEPTH; k++)
    begin : g_cell
        vwib_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .clear     (accept && first_of_model),
            .query     (query_reg),
            .tolerance (tol_reg),
            .tok_in    (link[k]),
            .tok_out   (link[k+1])
        );
    end

    assign chain_out = link[TABLE_DEPTH];

    // Result from the token leaving the last cell
    always_comb
    begin
        if (chain_out.found && chain_out.is_new)
            count_next = count_reg + 1'b1;
        else
            count_next = count_reg;
        idx_wide   = (IDX_W+OUT_IDX_W)'(chain_out.idx);
        count_wide = (COUNT_W+OUT_COUNT_W)'(count_next);
        chain_res.vertex_index = chain_out.found ? idx_wide[OUT_IDX_W-1:0] : '0;
        chain_res.is_new       = chain_out.found && chain_out.is_new;
        chain_res.table_full   = !chain_out.found;
        chain_res.unique_count = count_wide[OUT_COUNT_W-1:0];
    end

    // Output slot and holding slot control
    assign slot_free = !out_valid_reg || out_ready;
    assign load_out  = (chain_out.active || pend_reg) && slot_free;

    always_comb
    begin
        busy_next      = busy_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (accept)
            busy_next = 1'b1;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            pend_next      = 1'b0;
            busy_next      = 1'b0;
        end
        else if (chain_out.active)
        begin
            pend_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            if (accept && first_of_model)
                count_reg <= '0;
            else if (chain_out.active)
                count_reg <= count_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (chain_out.active && !load_out)
            pend_res_reg <= chain_res;
        if (load_out)
            out_res_reg <= pend_reg ? pend_res_reg : chain_res;
    end

    assign out_valid    = out_valid_reg;
    assign vertex_index = out_res_reg.vertex_index;
    assign is_new       = out_res_reg.is_new;
    assign table_full   = out_res_reg.table_full;
    assign unique_count = out_res_reg.unique_count;

`ifndef NO_ASSERTIONS
    // A new entry is only appended below the table size
    a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
        chain_out.active && chain_out.found && chain_out.is_new
        |-> count_reg < COUNT_W'(TABLE_DEPTH))
        else $error("append on a full table");

    // An appended entry lands at the current count
    a_append_slot: assert property (@(posedge clk) disable iff (!rst_n)
        chain_out.active && chain_out.found && chain_out.is_new
        |-> chain_out.idx == count_reg[IDX_W-1:0])
        else $error("append index differs from count");

    // A token only leaves the chain while a request is in flight
    a_token_busy: assert property (@(posedge clk) disable iff (!rst_n)
        chain_out.active |-> busy_reg && !pend_reg)
        else $error("stray search token");

    // A held result keeps the block busy
    a_pend_busy: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> busy_reg && out_valid_reg)
        else $error("held result without a busy block");
`endif

endmodule

`default_nettype wire
